/* rtl/fpls_pkg.sv */
// Shared types and constants of the five-point Laplacian stencil.
package fpls_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int OUT_W     = SAMPLE_W + 3;
	localparam int POS_W     = 6;
	localparam int SIDE_W    = 7;
	localparam int MAX_SIDE  = 64;
	localparam int SIDE_MIN  = 2;
	localparam int SIDE_RST  = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W    = 2;
	localparam int QCNT_W    = QPTR_W + 1;

	// Result kinds of one request, bit positions in the emit mask.
	localparam int EMIT_BELOW = 0;  // centre one row up, completed by this sample
	localparam int EMIT_LEFT  = 1;  // last row: centre one column left
	localparam int EMIT_FINAL = 2;  // last grid point itself
	localparam int EMIT_W     = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [POS_W-1:0]           pos_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		sample_t             sample;
		pos_t                col;
		pos_t                row;
		logic                has_up;
		logic                has_left;
		logic                has_left2;
		logic                has_right;
		logic                col_last;
		logic [EMIT_W-1:0]   emit;
	} entry_t;

	// One line store word: row just above and row two above, same column.
	typedef struct packed {
		sample_t mid;
		sample_t up;
	} line_word_t;

endpackage

/* rtl/fpls_front.sv */
// Front part: grid side register, raster counters and request classification.
module fpls_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpls_pkg::SIDE_W-1:0]         cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  fpls_pkg::sample_t                   sample,
	input  logic                                q_full,
	output logic                                push,
	output fpls_pkg::entry_t                    entry
);

	logic [fpls_pkg::SIDE_W-1:0] grid_side_q;
	logic [fpls_pkg::SIDE_W-1:0] side;
	logic [fpls_pkg::SIDE_W-1:0] side_m1;
	fpls_pkg::pos_t              col_q;
	fpls_pkg::pos_t              row_q;
	logic                        last_col;
	logic                        last_row;

	// Clamp the side into the supported range.
	always_comb begin
		if (grid_side_q < fpls_pkg::SIDE_W'(fpls_pkg::SIDE_MIN)) begin
			side = fpls_pkg::SIDE_W'(fpls_pkg::SIDE_MIN);
		end else if (grid_side_q > fpls_pkg::SIDE_W'(fpls_pkg::MAX_SIDE)) begin
			side = fpls_pkg::SIDE_W'(fpls_pkg::MAX_SIDE);
		end else begin
			side = grid_side_q;
		end
	end

	assign side_m1  = side - fpls_pkg::SIDE_W'(1);
	assign last_col = ({1'b0, col_q} == side_m1);
	assign last_row = ({1'b0, row_q} == side_m1);

	assign sample_stall = q_full;
	assign push         = sample_valid && !q_full;

	always_comb begin
		entry.sample    = sample;
		entry.col       = col_q;
		entry.row       = row_q;
		entry.has_up    = (row_q >= fpls_pkg::POS_W'(2));
		entry.has_left  = (col_q != '0);
		entry.has_left2 = (col_q >= fpls_pkg::POS_W'(2));
		entry.has_right = !last_col;
		entry.col_last  = last_col;
		entry.emit                        = '0;
		entry.emit[fpls_pkg::EMIT_BELOW]  = (row_q != '0);
		entry.emit[fpls_pkg::EMIT_LEFT]   = last_row && (col_q != '0);
		entry.emit[fpls_pkg::EMIT_FINAL]  = last_row && last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= fpls_pkg::SIDE_W'(fpls_pkg::SIDE_RST);
			col_q       <= '0;
			row_q       <= '0;
		end else if (cfg_we) begin
			grid_side_q <= cfg_data;
			col_q       <= '0;
			row_q       <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + fpls_pkg::POS_W'(1);
			end else begin
				col_q <= col_q + fpls_pkg::POS_W'(1);
			end
		end
	end

endmodule

/* rtl/fpls_queue.sv */
// Short request queue between the front and the back.
module fpls_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fpls_pkg::entry_t  push_data,
	input  logic              pop,
	output fpls_pkg::entry_t  head,
	output logic              full,
	output logic              not_empty
);

	fpls_pkg::entry_t             slot_q [fpls_pkg::QUEUE_DEPTH];
	logic [fpls_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [fpls_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [fpls_pkg::QCNT_W-1:0]  count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full      = (count_q == fpls_pkg::QCNT_W'(fpls_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + fpls_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + fpls_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + fpls_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - fpls_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/fpls_back.sv */
// Back part: line store, stencil window, result sequencing and output register.
module fpls_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_not_empty,
	input  fpls_pkg::entry_t                    q_head,
	output logic                                q_pop,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [fpls_pkg::OUT_W-1:0]   laplace_value,
	output fpls_pkg::pos_t                      column,
	output fpls_pkg::pos_t                      row,
	output logic                                last_of_run,
	output logic                                grid_done
);

	fpls_pkg::line_word_t             line_mem [fpls_pkg::MAX_SIDE];
	fpls_pkg::line_word_t             rdata_q;
	fpls_pkg::pos_t                   rd_addr;

	logic                             valid_s1;
	logic [fpls_pkg::EMIT_W-1:0]      pend_s1;
	fpls_pkg::entry_t                 ent_s1;
	fpls_pkg::line_word_t             cur_s1;
	fpls_pkg::sample_t                left_s1;
	fpls_pkg::sample_t                prev1_s1;
	fpls_pkg::sample_t                prev2_s1;

	logic [fpls_pkg::EMIT_W-1:0]      pick;
	logic [fpls_pkg::EMIT_W-1:0]      rest;
	logic                             out_load;
	logic                             s1_done;

	fpls_pkg::sample_t                ctr;
	fpls_pkg::sample_t                nb0;
	fpls_pkg::sample_t                nb1;
	fpls_pkg::sample_t                nb2;
	fpls_pkg::sample_t                nb3;
	logic signed [fpls_pkg::OUT_W-1:0] e_ctr;
	logic signed [fpls_pkg::OUT_W-1:0] e0;
	logic signed [fpls_pkg::OUT_W-1:0] e1;
	logic signed [fpls_pkg::OUT_W-1:0] e2;
	logic signed [fpls_pkg::OUT_W-1:0] e3;
	logic signed [fpls_pkg::OUT_W-1:0] value;
	fpls_pkg::pos_t                   res_col;
	fpls_pkg::pos_t                   res_row;

	// Lowest pending result goes first: ascending raster order.
	always_comb begin
		pick = '0;
		if (pend_s1[fpls_pkg::EMIT_BELOW]) begin
			pick[fpls_pkg::EMIT_BELOW] = 1'b1;
		end else if (pend_s1[fpls_pkg::EMIT_LEFT]) begin
			pick[fpls_pkg::EMIT_LEFT] = 1'b1;
		end else begin
			pick[fpls_pkg::EMIT_FINAL] = pend_s1[fpls_pkg::EMIT_FINAL];
		end
	end

	assign rest     = pend_s1 & ~pick;
	assign out_load = valid_s1 && (pend_s1 != '0) && (!result_valid || !result_stall);
	assign s1_done  = !valid_s1 || (pend_s1 == '0) || (out_load && (rest == '0));
	assign q_pop    = q_not_empty && s1_done;

	// Prefetch the next column's word; the last column wraps to column zero.
	assign rd_addr = q_head.col_last ? '0 : q_head.col + fpls_pkg::POS_W'(1);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			line_mem[q_head.col] <= '{mid: q_head.sample, up: rdata_q.mid};
			rdata_q              <= line_mem[rd_addr];
		end
	end

	// Window data: shift on every pop so the history stays contiguous.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_s1   <= q_head;
			cur_s1   <= rdata_q;
			left_s1  <= cur_s1.mid;
			prev1_s1 <= ent_s1.sample;
			prev2_s1 <= prev1_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_s1  <= '0;
		end else if (q_pop) begin
			valid_s1 <= 1'b1;
			pend_s1  <= q_head.emit;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
			pend_s1  <= '0;
		end else if (out_load) begin
			pend_s1  <= rest;
		end
	end

	// Operand selection per result kind; absent neighbors read as zero.
	always_comb begin
		ctr     = cur_s1.mid;
		nb0     = ent_s1.sample;
		nb1     = ent_s1.has_up ? cur_s1.up : '0;
		nb2     = ent_s1.has_left ? left_s1 : '0;
		nb3     = ent_s1.has_right ? rdata_q.mid : '0;
		res_col = ent_s1.col;
		res_row = ent_s1.row - fpls_pkg::POS_W'(1);
		if (pick[fpls_pkg::EMIT_LEFT]) begin
			ctr     = prev1_s1;
			nb1     = left_s1;
			nb2     = ent_s1.has_left2 ? prev2_s1 : '0;
			nb3     = '0;
			res_col = ent_s1.col - fpls_pkg::POS_W'(1);
			res_row = ent_s1.row;
		end else if (pick[fpls_pkg::EMIT_FINAL]) begin
			ctr     = ent_s1.sample;
			nb0     = prev1_s1;
			nb1     = cur_s1.mid;
			nb2     = '0;
			nb3     = '0;
			res_row = ent_s1.row;
		end
	end

	assign e_ctr = {{(fpls_pkg::OUT_W-fpls_pkg::SAMPLE_W){ctr[fpls_pkg::SAMPLE_W-1]}}, ctr};
	assign e0    = {{(fpls_pkg::OUT_W-fpls_pkg::SAMPLE_W){nb0[fpls_pkg::SAMPLE_W-1]}}, nb0};
	assign e1    = {{(fpls_pkg::OUT_W-fpls_pkg::SAMPLE_W){nb1[fpls_pkg::SAMPLE_W-1]}}, nb1};
	assign e2    = {{(fpls_pkg::OUT_W-fpls_pkg::SAMPLE_W){nb2[fpls_pkg::SAMPLE_W-1]}}, nb2};
	assign e3    = {{(fpls_pkg::OUT_W-fpls_pkg::SAMPLE_W){nb3[fpls_pkg::SAMPLE_W-1]}}, nb3};
	assign value = (e_ctr <<< 2) - e0 - e1 - e2 - e3;

	always_ff @(posedge clk) begin
		if (out_load) begin
			laplace_value <= value;
			column        <= res_col;
			row           <= res_row;
			last_of_run   <= (rest == '0);
			grid_done     <= pick[fpls_pkg::EMIT_FINAL];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

endmodule

/* rtl/five_point_laplacian_stencil_top.sv */
// Top level of the five-point Laplacian stencil over a streamed square grid.
//
//   channel   direction  handshake                   payload
//   sample    in         sample_valid/sample_stall   sample
//   result    out        result_valid/result_stall   laplace_value, column, row,
//                                                    last_of_run, grid_done
//   config    in         cfg_we                      cfg_data (grid side)
//
// One sample request is taken per cycle while the queue is not full. A
// sample in the last grid row past its first column causes two results, the
// final grid point three, and holds the back part until its results are
// loaded; the four-deep request queue absorbs short bursts, and over a long
// last row the input stalls. The line store is one 64-word memory, one
// write and one read per request. Reset clears counters, queue and valid
// flags and sets the side to 64; line contents are left undefined. Both
// sides stall on their own.
module five_point_laplacian_stencil_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpls_pkg::SIDE_W-1:0]         cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [fpls_pkg::SAMPLE_W-1:0] sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [fpls_pkg::OUT_W-1:0]   laplace_value,
	output logic [fpls_pkg::POS_W-1:0]          column,
	output logic [fpls_pkg::POS_W-1:0]          row,
	output logic                                last_of_run,
	output logic                                grid_done
);

	fpls_pkg::entry_t push_entry;
	fpls_pkg::entry_t head_entry;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_not_empty;

	// Classify each sample request and advance the raster position.
	fpls_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_full       (q_full),
		.push         (push),
		.entry        (push_entry)
	);

	// Hold classified requests while the back part is busy or stalled.
	fpls_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.head      (head_entry),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// Update the line store and emit the results of each request in order.
	fpls_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_head        (head_entry),
		.q_pop         (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.laplace_value (laplace_value),
		.column        (column),
		.row           (row),
		.last_of_run   (last_of_run),
		.grid_done     (grid_done)
	);

endmodule
